[rtl/tbmcd_pkg.sv]
// ----------------------------------------------------------------------------
// tbmcd_pkg
// shared button codes, motor command codes and state types for the
// two-button motor command decoder
// ----------------------------------------------------------------------------
package tbmcd_pkg;

    // decoded button levels
    typedef logic [2:0] t_btn;

    localparam t_btn BTN_OFF     = 3'd0;
    localparam t_btn BTN_MAN_OPN = 3'd1;
    localparam t_btn BTN_AUT_OPN = 3'd2;
    localparam t_btn BTN_MAN_CLS = 3'd3;
    localparam t_btn BTN_AUT_CLS = 3'd4;

    // motor command codes as seen on the output port
    typedef logic [2:0] t_mc_code;

    localparam t_mc_code MC_STOP    = 3'd0;
    localparam t_mc_code MC_OFF     = 3'd1;
    localparam t_mc_code MC_MAN_OPN = 3'd2;
    localparam t_mc_code MC_AUT_OPN = 3'd3;
    localparam t_mc_code MC_MAN_CLS = 3'd4;
    localparam t_mc_code MC_AUT_CLS = 3'd5;
    localparam t_mc_code MC_REV_OPN = 3'd6;
    localparam t_mc_code MC_REV_CLS = 3'd7;

    // command state machine, one-hot
    typedef enum logic [7:0] {
        ST_STOP    = 8'b0000_0001,
        ST_OFF     = 8'b0000_0010,
        ST_MAN_OPN = 8'b0000_0100,
        ST_AUT_OPN = 8'b0000_1000,
        ST_MAN_CLS = 8'b0001_0000,
        ST_AUT_CLS = 8'b0010_0000,
        ST_REV_OPN = 8'b0100_0000,
        ST_REV_CLS = 8'b1000_0000
    } t_mc_state;

    // full decoder state
    typedef struct packed {
        t_mc_state cmd;
        logic      auto_open_first;
        logic      auto_close_first;
    } t_state;

    // one-hot state to output code
    function automatic t_mc_code state_to_code(input t_mc_state st);
        t_mc_code code;
        unique case (st)
            ST_STOP:    code = MC_STOP;
            ST_OFF:     code = MC_OFF;
            ST_MAN_OPN: code = MC_MAN_OPN;
            ST_AUT_OPN: code = MC_AUT_OPN;
            ST_MAN_CLS: code = MC_MAN_CLS;
            ST_AUT_CLS: code = MC_AUT_CLS;
            ST_REV_OPN: code = MC_REV_OPN;
            ST_REV_CLS: code = MC_REV_CLS;
            default:    code = MC_STOP;
        endcase
        return code;
    endfunction

endpackage

[rtl/tbmcd_next.sv]
// ----------------------------------------------------------------------------
// tbmcd_next
// next-state logic of the motor command state machine for one button sample
// ----------------------------------------------------------------------------
module tbmcd_next (
    input  tbmcd_pkg::t_state i_cur,
    input  tbmcd_pkg::t_btn   i_b1,
    input  tbmcd_pkg::t_btn   i_b2,
    input  logic              i_normed,
    output tbmcd_pkg::t_state o_nxt
);
    import tbmcd_pkg::*;

    logic b1_off;
    logic b2_off;

    assign b1_off = (i_b1 == BTN_OFF);
    assign b2_off = (i_b2 == BTN_OFF);

    always_comb begin
        o_nxt = i_cur;
        unique case (i_cur.cmd)
            ST_STOP: begin
                if (b1_off && b2_off) o_nxt.cmd = ST_OFF;
            end
            ST_OFF: begin
                if (i_b1 == BTN_AUT_OPN) begin
                    if (i_normed) begin
                        o_nxt.cmd             = ST_AUT_OPN;
                        o_nxt.auto_open_first = 1'b1;
                    end else begin
                        o_nxt.cmd = ST_MAN_OPN;
                    end
                end
                // close wins when both auto levels arrive together
                if (i_b2 == BTN_AUT_CLS) begin
                    if (i_normed) begin
                        o_nxt.cmd              = ST_AUT_CLS;
                        o_nxt.auto_close_first = 1'b1;
                    end else begin
                        o_nxt.cmd = ST_MAN_CLS;
                    end
                end
            end
            ST_MAN_OPN: begin
                if (b1_off) o_nxt.cmd = ST_OFF;
                if (!b2_off) o_nxt.cmd = ST_STOP;
            end
            ST_AUT_OPN: begin
                if (i_cur.auto_open_first) begin
                    if (i_b1 == BTN_MAN_OPN) begin
                        o_nxt.cmd             = ST_MAN_OPN;
                        o_nxt.auto_open_first = 1'b0;
                    end else if (b1_off) begin
                        o_nxt.auto_open_first = 1'b0;
                    end
                end else if (!b1_off) begin
                    o_nxt.cmd = ST_STOP;
                end
                if (!b2_off) begin
                    o_nxt.cmd             = ST_STOP;
                    o_nxt.auto_open_first = 1'b0;
                end
            end
            ST_MAN_CLS: begin
                if (!b1_off) o_nxt.cmd = ST_STOP;
                if (b2_off) o_nxt.cmd = ST_OFF;
            end
            ST_AUT_CLS: begin
                if (!b1_off) begin
                    o_nxt.cmd              = ST_STOP;
                    o_nxt.auto_close_first = 1'b0;
                end
                if (o_nxt.auto_close_first) begin
                    if (i_b2 == BTN_AUT_CLS) begin
                        o_nxt.cmd = ST_AUT_CLS;
                    end else if (i_b2 == BTN_MAN_CLS) begin
                        o_nxt.cmd              = ST_MAN_CLS;
                        o_nxt.auto_close_first = 1'b0;
                    end else if (b2_off) begin
                        o_nxt.cmd              = ST_AUT_CLS;
                        o_nxt.auto_close_first = 1'b0;
                    end
                end else if (!b2_off) begin
                    o_nxt.cmd = ST_STOP;
                end
            end
            ST_REV_OPN, ST_REV_CLS: begin
                o_nxt = i_cur;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

[rtl/two_button_motor_command_decoder.sv]
// ----------------------------------------------------------------------------
// two_button_motor_command_decoder
// one-touch window switch logic: turns open/close button samples into a
// motor command
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_ready carry one button sample request
//     (open button level, close button level, motor normed flag)
//   output channel: o_out_valid / i_out_ready carry one motor command per
//     request, in request order
//   path: input register, then the state update writes the result
//     register, which drives o_out_valid
//   throughput: 1 request per cycle while i_out_ready does not stall; the
//     next-state logic between the input and result registers is combinational
//   reset: synchronous active-low i_rst_n empties both stages and sets the
//     command state to off with both first-press flags clear
//   stall: while i_out_ready is low the result holds; one more request can
//     wait in the input register, after which o_in_ready drops
// ----------------------------------------------------------------------------
module two_button_motor_command_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tbmcd_pkg::t_btn      i_open_button_cmd,
    input  tbmcd_pkg::t_btn      i_close_button_cmd,
    input  logic                 i_motor_normed,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tbmcd_pkg::t_mc_code  o_drive_cmd
);
    import tbmcd_pkg::*;

    // input stage
    logic     r_in_vld;
    t_btn     r_b1;
    t_btn     r_b2;
    logic     r_normed;

    // decoder state and result stage
    t_state   r_state;
    t_state   n_state;
    logic     r_out_vld;
    t_mc_code r_out_cmd;

    logic     out_free;   // result register can take a new command
    logic     advance;    // input stage moves into the result stage

    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    tbmcd_next u_next (
        .i_cur    (r_state),
        .i_b1     (r_b1),
        .i_b2     (r_b2),
        .i_normed (r_normed),
        .o_nxt    (n_state)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_b1     <= i_open_button_cmd;
            r_b2     <= i_close_button_cmd;
            r_normed <= i_motor_normed;
        end
    end

    // state update and result register; state and command load only when a request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cmd              <= ST_OFF;
            r_state.auto_open_first  <= 1'b0;
            r_state.auto_close_first <= 1'b0;
            r_out_vld                <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
        if (advance) begin
            r_out_cmd <= state_to_code(n_state.cmd);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive_cmd = r_out_cmd;

`ifndef SYNTH
    // reverse commands cannot be reached from reset
    a_no_reverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_cmd != MC_REV_OPN) && (o_drive_cmd != MC_REV_CLS))
        else $error("reverse motor command reached");

    // auto close first-press flag only lives inside the auto close state
    a_close_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.auto_close_first |-> (r_state.cmd == ST_AUT_CLS))
        else $error("auto close flag set outside auto close");

    // both stages full and receiver stalled: no new request taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("request accepted while pipeline full");

    // the decoder state only moves when a request passes to the result stage
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("decoder state changed without a request");
`endif

endmodule
